// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker of the gait phase generator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define GPG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define GPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gpg_pkg.sv =====
// Gait phase generator: shared constants, register indexes, sequencer states
// and the leg offset table. No dependencies.
package gpg_pkg;

  localparam int PHASE_BITS    = 24;
  localparam int PROGRESS_BITS = 16;
  localparam int PRODUCT_FRAC  = 28;
  localparam int NUM_LEGS      = 4;
  localparam int INC_SHR = (PHASE_BITS <= PRODUCT_FRAC) ? PRODUCT_FRAC - PHASE_BITS : 0;
  localparam int INC_SHL = (PHASE_BITS >  PRODUCT_FRAC) ? PHASE_BITS - PRODUCT_FRAC : 0;
  localparam int DIV_CNT_BITS  = $clog2(PROGRESS_BITS + 1);

  localparam logic [1:0] REG_GAIT_MODE     = 2'd0;
  localparam logic [1:0] REG_STEP_RATE     = 2'd1;
  localparam logic [1:0] REG_DUTY_FRACTION = 2'd2;
  localparam logic [1:0] REG_STANDING      = 2'd3;

  typedef enum logic [1:0] {
    GAIT_TROT  = 2'd0,
    GAIT_WALK  = 2'd1,
    GAIT_PACE  = 2'd2,
    GAIT_BOUND = 2'd3
  } gait_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH
  } seq_state_t;

  // Quarter-cycle offset of a leg (FL, FR, RL, RR) for a gait.
  function automatic logic [1:0] leg_quarter(input gait_t mode, input logic [1:0] leg);
    logic [7:0] row;
    begin
      case (mode)
        GAIT_TROT:  row = {2'd0, 2'd2, 2'd2, 2'd0};
        GAIT_WALK:  row = {2'd0, 2'd2, 2'd1, 2'd3};
        GAIT_PACE:  row = {2'd0, 2'd2, 2'd0, 2'd2};
        GAIT_BOUND: row = {2'd0, 2'd0, 2'd2, 2'd2};
        default:    row = 8'd0;
      endcase
      leg_quarter = row[(3 - leg) * 2 +: 2];
    end
  endfunction

endpackage

// ===== hw/rtl/gait_phase_generator_unit.sv =====
// Gait phase generator top level: registers, sequencer, phase accumulator.
// Depends on gpg_pkg and gpg_div.
//
// Input channel: in_valid/in_stall carries one control tick (time_step,
// restart). Output channel: out_valid/out_stall carries swing and progress
// for the four legs. Each transfer in gives exactly one transfer out.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 gait_mode, 1 step_rate, 2 duty_fraction, 3 standing); write only idle.
// One item is worked at a time; the tick costs one multiply and, unless
// standing, one phase add (a restart clears it instead), then four 16-step
// divisions on one shared divider; standing skips them and progress is zero.
// in_stall is high from the transfer until the result is loaded.
// The result register holds while out_stall is high; a new tick may be taken
// while it waits, but its result is loaded only once the old one has left.
// Reset (rst, synchronous) restores register defaults, clears the phase and
// empties the output register.
module gait_phase_generator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       time_step,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              front_left_swing,
  output logic [gpg_pkg::PROGRESS_BITS-1:0] front_left_progress,
  output logic                              front_right_swing,
  output logic [gpg_pkg::PROGRESS_BITS-1:0] front_right_progress,
  output logic                              rear_left_swing,
  output logic [gpg_pkg::PROGRESS_BITS-1:0] rear_left_progress,
  output logic                              rear_right_swing,
  output logic [gpg_pkg::PROGRESS_BITS-1:0] rear_right_progress
);
  import gpg_pkg::*;

  gait_t                    gait_mode;
  logic signed [15:0]       step_rate;
  logic [15:0]              duty_fraction;
  logic                     standing;

  seq_state_t               state, state_next;
  logic                     accept, adv_en, div_start, store_en, out_load;

  logic [PHASE_BITS-1:0]    phase;
  logic signed [32:0]       prod;
  logic                     restart_r;
  logic [1:0]               leg;
  logic                     leg_swing;
  logic [NUM_LEGS-1:0]      swing_w;
  logic [PROGRESS_BITS-1:0] prog_w [NUM_LEGS];

  logic signed [63:0]       prod_ext;
  logic [PHASE_BITS-1:0]    inc;
  logic [PHASE_BITS-1:0]    duty_w;
  logic [PHASE_BITS-1:0]    local_ph;
  logic                     stance;
  logic [PHASE_BITS-1:0]    numer;
  logic [PHASE_BITS:0]      denom;
  logic                     div_done;
  logic [PROGRESS_BITS-1:0] quot;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gait_mode     <= GAIT_TROT;
      step_rate     <= '0;
      duty_fraction <= 16'd32768;
      standing      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIT_MODE:     gait_mode     <= gait_t'(cfg_data[1:0]);
        REG_STEP_RATE:     step_rate     <= cfg_data;
        REG_DUTY_FRACTION: duty_fraction <= cfg_data;
        REG_STANDING:      standing      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    adv_en     = 1'b0;
    div_start  = 1'b0;
    store_en   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept     = 1'b1;
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        adv_en     = 1'b1;
        state_next = standing ? ST_FINISH : ST_SETUP;
      end
      ST_SETUP: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          store_en   = 1'b1;
          state_next = (leg == 2'(NUM_LEGS - 1)) ? ST_FINISH : ST_SETUP;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // phase datapath
  assign prod_ext = {{31{prod[32]}}, prod};
  assign inc      = PHASE_BITS'((prod_ext >>> INC_SHR) << INC_SHL);
  assign duty_w   = PHASE_BITS'(duty_fraction) << (PHASE_BITS - 16);
  assign local_ph = phase + (PHASE_BITS'(leg_quarter(gait_mode, leg)) << (PHASE_BITS - 2));
  assign stance   = (local_ph < duty_w);
  assign numer    = stance ? local_ph : local_ph - duty_w;
  assign denom    = stance ? {1'b0, duty_w}
                           : {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, duty_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (adv_en) begin
      if (restart_r) begin
        phase <= '0;
      end else if (!standing) begin
        phase <= phase + inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod      <= step_rate * $signed({1'b0, time_step});
      restart_r <= restart;
    end
    if (adv_en) begin
      leg     <= '0;
      swing_w <= '0;
      for (int i = 0; i < NUM_LEGS; i++) begin
        prog_w[i] <= '0;
      end
    end
    if (div_start) begin
      leg_swing <= !stance;
    end
    if (store_en) begin
      swing_w[leg] <= leg_swing;
      prog_w[leg]  <= quot;
      leg          <= leg + 1'b1;
    end
  end

  gpg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      front_left_swing     <= swing_w[0];
      front_left_progress  <= prog_w[0];
      front_right_swing    <= swing_w[1];
      front_right_progress <= prog_w[1];
      rear_left_swing      <= swing_w[2];
      rear_left_progress   <= prog_w[2];
      rear_right_swing     <= swing_w[3];
      rear_right_progress  <= prog_w[3];
    end
  end

endmodule

// ===== hw/rtl/gpg_div.sv =====
// Gait phase generator: restoring divider, one quotient bit per cycle.
// Numerator must be below the divisor. Depends on gpg_pkg.
module gpg_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [gpg_pkg::PHASE_BITS-1:0]   numer,
  input  logic [gpg_pkg::PHASE_BITS:0]     denom,
  output logic                             done,
  output logic [gpg_pkg::PROGRESS_BITS-1:0] quot
);
  import gpg_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [PHASE_BITS:0]     rem;
  logic [PHASE_BITS:0]     den;
  logic [PHASE_BITS+1:0]   shifted;
  logic [PHASE_BITS+1:0]   diff;
  logic                    qbit;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign qbit    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(PROGRESS_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, numer};
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[PHASE_BITS:0] : shifted[PHASE_BITS:0];
      quot <= {quot[PROGRESS_BITS-2:0], qbit};
    end
  end

endmodule

// ===== hw/rtl/gpg_checker.sv =====
// Gait phase generator: port-level checker and its bind to the top level.
// Depends on gpg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpg_port_assertions (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [gpg_pkg::PROGRESS_BITS-1:0] front_left_progress
);
  import gpg_pkg::*;

  logic in_xfer;
  logic [PROGRESS_BITS-1:0] fl_prog;

  assign in_xfer = in_valid && !in_stall;
  assign fl_prog = front_left_progress;

  // busy straight after taking a tick
  `GPG_ASSERT(a_busy_after_in, clk, rst, in_xfer |=> in_stall, "in_stall low after transfer")
  // no result in the cycle after a tick is taken
  `GPG_ASSERT(a_no_early_out, clk, rst, in_xfer |=> !$rose(out_valid), "result too early")
  // reset empties the output register
  `GPG_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "out_valid after reset")
  // stalled result holds
  `GPG_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(fl_prog), "stalled result changed")

endmodule

bind gait_phase_generator_unit gpg_port_assertions u_gpg_port_assertions (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .front_left_progress (front_left_progress)
);

// ===== verif/gpg_checker.sv =====
// Checker for the gait phase generator: watches config writes and both channels,
// keeps its own phase and register copies and compares every output transfer.
// Depends on gpg_pkg.
module gpg_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [15:0]                       time_step,
  input  logic                              restart,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              front_left_swing,
  input  logic [gpg_pkg::PROGRESS_BITS-1:0] front_left_progress,
  input  logic                              front_right_swing,
  input  logic [gpg_pkg::PROGRESS_BITS-1:0] front_right_progress,
  input  logic                              rear_left_swing,
  input  logic [gpg_pkg::PROGRESS_BITS-1:0] rear_left_progress,
  input  logic                              rear_right_swing,
  input  logic [gpg_pkg::PROGRESS_BITS-1:0] rear_right_progress,
  output int                                fault_count,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpg_pkg::*;

  typedef struct packed {
    logic [NUM_LEGS-1:0]                    swing;
    logic [NUM_LEGS-1:0][PROGRESS_BITS-1:0] progress;
  } leg_report_t;

  string leg_name [NUM_LEGS] = '{"front_left", "front_right", "rear_left", "rear_right"};

  gait_t                  mode_q;
  logic signed [15:0]     rate_q;
  logic [15:0]            duty_q;
  logic                   stand_q;
  logic [PHASE_BITS-1:0]  phase_q;
  leg_report_t            leg_reports_q [$];

  // legs FL, FR, RL, RR
  function automatic logic [1:0] quarter_offset(input gait_t mode, input int leg);
    logic [1:0] offs [NUM_LEGS];
    case (mode)
      GAIT_WALK:  offs = '{2'd0, 2'd2, 2'd1, 2'd3};
      GAIT_PACE:  offs = '{2'd0, 2'd2, 2'd0, 2'd2};
      GAIT_BOUND: offs = '{2'd0, 2'd0, 2'd2, 2'd2};
      default:    offs = '{2'd0, 2'd2, 2'd2, 2'd0};
    endcase
    return offs[leg];
  endfunction

  // rate * dt has 28 fraction bits of a gait period; floor down to phase resolution
  function automatic logic [PHASE_BITS-1:0] phase_step(input logic signed [15:0] rate,
                                                       input logic [15:0] dt);
    logic signed [32:0] prod;
    logic signed [32:0] shifted;
    prod = rate * $signed({1'b0, dt});
    shifted = prod >>> (PRODUCT_FRAC - PHASE_BITS);
    return shifted[PHASE_BITS-1:0];
  endfunction

  function automatic leg_report_t predict_legs(input logic [PHASE_BITS-1:0] ph,
                                               input gait_t mode,
                                               input logic [15:0] duty,
                                               input logic stand);
    leg_report_t                         r;
    logic [PHASE_BITS-1:0]               loc;
    logic [PHASE_BITS-1:0]               duty_w;
    logic [PHASE_BITS:0]                 span;
    logic [PHASE_BITS+PROGRESS_BITS-1:0] quo;
    r = '0;
    duty_w = {duty, {(PHASE_BITS-16){1'b0}}};
    span = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, duty_w};
    if (!stand) begin
      for (int leg = 0; leg < NUM_LEGS; leg++) begin
        loc = ph + {quarter_offset(mode, leg), {(PHASE_BITS-2){1'b0}}};
        if (loc < duty_w) begin
          quo = {loc, {PROGRESS_BITS{1'b0}}} / duty_w;
          r.swing[leg] = 1'b0;
        end else begin
          quo = {loc - duty_w, {PROGRESS_BITS{1'b0}}} / span;
          r.swing[leg] = 1'b1;
        end
        r.progress[leg] = quo[PROGRESS_BITS-1:0];
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fault_count++;
  endtask

  initial begin
    fault_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    leg_report_t want;
    leg_report_t got;
    if (rst) begin
      mode_q  = GAIT_TROT;
      rate_q  = '0;
      duty_q  = 16'd32768;
      stand_q = 1'b1;
      phase_q = '0;
      leg_reports_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.swing = {rear_right_swing, rear_left_swing, front_right_swing, front_left_swing};
        got.progress[0] = front_left_progress;
        got.progress[1] = front_right_progress;
        got.progress[2] = rear_left_progress;
        got.progress[3] = rear_right_progress;
        if (leg_reports_q.size() == 0) begin
          flag_error("output transfer with nothing pending");
        end else begin
          want = leg_reports_q.pop_front();
          for (int leg = 0; leg < NUM_LEGS; leg++) begin
            if (got.swing[leg] !== want.swing[leg])
              flag_error($sformatf("%s_swing expected %0d got %0d", leg_name[leg],
                                   want.swing[leg], got.swing[leg]));
            if (got.progress[leg] !== want.progress[leg])
              flag_error($sformatf("%s_progress expected %0d got %0d", leg_name[leg],
                                   want.progress[leg], got.progress[leg]));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (restart)
          phase_q = '0;
        else if (!stand_q)
          phase_q = phase_q + phase_step(rate_q, time_step);
        leg_reports_q.push_back(predict_legs(phase_q, mode_q, duty_q, stand_q));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIT_MODE:     mode_q  = gait_t'(cfg_data[1:0]);
          REG_STEP_RATE:     rate_q  = cfg_data;
          REG_DUTY_FRACTION: duty_q  = cfg_data;
          REG_STANDING:      stand_q = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = leg_reports_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the gait phase generator testbench: clock, reset, register setup,
// bursty tick stimulus, output back-pressure, watchdog and verdict.
// Depends on gpg_pkg, gait_phase_generator_unit and gpg_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gpg_pkg::*;

  localparam int PERIOD     = 20;
  localparam int QUIET_MAX  = 3000;
  localparam int RAND_PHASE = 14;
  localparam int PHASE_LEN  = 50;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [15:0]              cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [15:0]              time_step;
  logic                     restart;
  logic                     out_valid;
  logic                     out_stall;
  logic                     front_left_swing;
  logic [PROGRESS_BITS-1:0] front_left_progress;
  logic                     front_right_swing;
  logic [PROGRESS_BITS-1:0] front_right_progress;
  logic                     rear_left_swing;
  logic [PROGRESS_BITS-1:0] rear_left_progress;
  logic                     rear_right_swing;
  logic [PROGRESS_BITS-1:0] rear_right_progress;
  int                       fault_count;
  int                       outstanding;
  int                       quiet_cycles;

  always #(PERIOD/2) clk = ~clk;

  gait_phase_generator_unit dut (.*);

  gpg_checker checker_i (.*);

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_all(input gait_t mode, input int rate, input int duty, input bit stand);
    drain();
    put_reg(REG_GAIT_MODE, 16'(mode));
    put_reg(REG_STEP_RATE, 16'(rate));
    put_reg(REG_DUTY_FRACTION, 16'(duty));
    put_reg(REG_STANDING, 16'(stand));
  endtask

  // valid stays high on return so a burst runs on without a gap
  task automatic send_tick(input logic [15:0] dt, input logic rs);
    in_valid  <= 1'b1;
    time_step <= dt;
    restart   <= rs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_random_tick();
    logic [15:0] dt;
    case ($urandom_range(0, 7))
      0:       dt = 16'd0;
      1:       dt = 16'hFFFF;
      2, 3:    dt = 16'($urandom_range(0, 255));
      default: dt = 16'($urandom_range(0, 65535));
    endcase
    send_tick(dt, $urandom_range(0, 15) == 0);
  endtask

  task automatic random_config();
    int rate;
    int duty;
    case ($urandom_range(0, 5))
      0:       rate = -32768;
      1:       rate = 32767;
      2:       rate = $urandom_range(0, 511) - 256;
      default: rate = $urandom_range(0, 65535) - 32768;
    endcase
    case ($urandom_range(0, 6))
      0:       duty = 1;
      1:       duty = 65535;
      2:       duty = 16384 * $urandom_range(1, 3);
      default: duty = $urandom_range(1, 65535);
    endcase
    set_all(gait_t'($urandom_range(0, 3)), rate, duty, $urandom_range(0, 9) == 0);
  endtask

  task automatic run_bursts(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_random_tick();
        burst--;
        left--;
      end
      case ($urandom_range(0, 9))
        0:       drain();
        1, 2, 3: ;
        default: pause_sender($urandom_range(1, 40));
      endcase
    end
  endtask

  // back-pressure: free, coin toss, mostly stalled, long runs
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 1) == 1;
          2:       out_stall <= $urandom_range(0, 9) < 8;
          default: out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    time_step = '0;
    restart   = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset state is standing: legs all stance, zero progress
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd0, 1'b1);

    set_all(GAIT_TROT, 32767, 32768, 1'b0);
    send_tick(16'd0, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd1, 1'b0);
    send_tick(16'd0, 1'b1);

    // narrowest stance, fastest reverse rate
    set_all(GAIT_WALK, -32768, 1, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd1, 1'b0);
    send_tick(16'd0, 1'b1);

    // widest stance, slowest rate: sub-step increments floor away
    set_all(GAIT_PACE, 1, 65535, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd15, 1'b0);
    send_tick(16'd16, 1'b0);

    // local phase exactly on the duty boundary, then wrap below zero
    set_all(GAIT_BOUND, -1, 16384, 1'b0);
    send_tick(16'd0, 1'b1);
    send_tick(16'd1, 1'b0);
    set_all(GAIT_WALK, -1, 16384, 1'b0);
    send_tick(16'd0, 1'b1);
    send_tick(16'd1, 1'b0);

    // standing freezes the phase; restart still clears it
    set_all(GAIT_WALK, 32767, 40000, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd100, 1'b1);
    set_all(GAIT_WALK, 32767, 40000, 1'b0);
    send_tick(16'd0, 1'b0);

    for (int p = 0; p < RAND_PHASE; p++) begin
      random_config();
      run_bursts(PHASE_LEN);
    end

    drain();
    repeat (100) @(negedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
